// ===== hw/rtl/pnd_pkg.sv =====
package pnd_pkg;

    localparam int TILE_DEPTH_DEF      = 65536;
    localparam int OUT_WIDTH_DEF       = 64;
    localparam int OUT_HEIGHT_DEF      = 40;
    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

    localparam logic [8:0] SOURCE_WIDTH_RST  = 9'd320;
    localparam logic [7:0] SOURCE_HEIGHT_RST = 8'd200;

    localparam logic [1:0] KIND_PALETTE = 2'd0;
    localparam logic [1:0] KIND_TILE    = 2'd1;
    localparam logic [1:0] KIND_ROW     = 2'd2;

    localparam logic [1:0] OP_PAL_WR  = 2'd0;
    localparam logic [1:0] OP_TILE_WR = 2'd1;
    localparam logic [1:0] OP_ROW     = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // widest x*height+y reachable from the register widths
    localparam int SCAN_ADDR_W = 17;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  pal_index;
        logic [17:0] rgb;
        logic [15:0] tile_addr;
        logic [7:0]  tile_value;
        logic [5:0]  row;
    } pnd_cmd_t;

    // (v*255+31)/63 == 4v + (3v+31)/63
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [7:0] t;
        logic [1:0] q;
        t = 8'(v) * 8'd3 + 8'd31;
        if (t >= 8'd189)
            q = 2'd3;
        else if (t >= 8'd126)
            q = 2'd2;
        else if (t >= 8'd63)
            q = 2'd1;
        else
            q = 2'd0;
        return {v, q};
    endfunction

endpackage

// ===== hw/rtl/pnd_front.sv =====
module pnd_front #(
    parameter int TILE_DEPTH      = pnd_pkg::TILE_DEPTH_DEF,
    parameter int PALETTE_ENTRIES = pnd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic              src_valid,
    output logic              src_stall,
    input  logic [1:0]        kind,
    input  logic [7:0]        palette_index,
    input  logic [5:0]        red6,
    input  logic [5:0]        green6,
    input  logic [5:0]        blue6,
    input  logic [15:0]       tile_address,
    input  logic [7:0]        tile_value,
    input  logic [5:0]        output_row,
    input  logic              queue_full,
    output logic              push,
    output pnd_pkg::pnd_cmd_t cmd
);
    import pnd_pkg::*;

    logic keep;

    always_comb
    begin
        cmd.pal_index  = palette_index;
        cmd.rgb        = {red6, green6, blue6};
        cmd.tile_addr  = tile_address;
        cmd.tile_value = tile_value;
        cmd.row        = output_row;
        cmd.op         = OP_ROW;
        keep           = 1'b0;
        case (kind)
            KIND_PALETTE:
            begin
                cmd.op = OP_PAL_WR;
                keep   = 32'(palette_index) < 32'(PALETTE_ENTRIES);
            end
            KIND_TILE:
            begin
                cmd.op = OP_TILE_WR;
                keep   = 32'(tile_address) < 32'(TILE_DEPTH);
            end
            KIND_ROW:
            begin
                cmd.op = OP_ROW;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign src_stall = queue_full;
    assign push      = src_valid && !queue_full && keep;

endmodule

// ===== hw/rtl/pnd_queue.sv =====
module pnd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pnd_pkg::pnd_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output pnd_pkg::pnd_cmd_t head
);
    import pnd_pkg::*;

    pnd_cmd_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]     count_reg, count_next;

    assign full  = count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== hw/rtl/pnd_back.sv =====
module pnd_back #(
    parameter int TILE_DEPTH      = pnd_pkg::TILE_DEPTH_DEF,
    parameter int OUT_WIDTH       = pnd_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT      = pnd_pkg::OUT_HEIGHT_DEF,
    parameter int PALETTE_ENTRIES = pnd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [8:0]        sw,
    input  logic [7:0]        sh,
    input  logic              queue_empty,
    input  pnd_pkg::pnd_cmd_t head,
    output logic              pop,
    output logic              pix_valid,
    input  logic              pix_stall,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic [5:0]        column,
    output logic              last
);
    import pnd_pkg::*;

    localparam int TILE_AW = $clog2(TILE_DEPTH);
    localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
    localparam int SCAN_W  = (TILE_AW > SCAN_ADDR_W) ? TILE_AW : SCAN_ADDR_W;

    // reciprocal multiply, exact for 14-bit row products and 9-bit widths
    localparam int Y_SHIFT = 22;
    localparam int X_SHIFT = 16;
    localparam logic [22:0] Y_MUL_C = 23'(((1 << Y_SHIFT) + OUT_HEIGHT - 1) / OUT_HEIGHT);
    localparam logic [16:0] X_MUL_C = 17'(((1 << X_SHIFT) + OUT_WIDTH - 1) / OUT_WIDTH);

    localparam logic [6:0] OW_C    = 7'(OUT_WIDTH);
    localparam logic [8:0] OW9_C   = 9'(OUT_WIDTH);
    localparam logic [5:0] OX_LAST = 6'(OUT_WIDTH - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SETUP = 2'd2;
    localparam logic [1:0] ST_RUN   = 2'd3;

    logic [7:0]  tile_mem [TILE_DEPTH];
    logic [17:0] pal_mem  [PALETTE_ENTRIES];

    logic [1:0]           state_reg, state_next;
    logic [13:0]          ny_reg, ny_next;
    logic [8:0]           nx_reg, nx_next;
    logic [5:0]           rx_reg, rx_next;
    logic [16:0]          qsh_reg, qsh_next;
    logic [SCAN_W-1:0]    addr_reg, addr_next;
    logic [5:0]           acc_reg, acc_next;
    logic [5:0]           ox_reg, ox_next;

    logic        v1_reg, t_ok1_reg, last1_reg;
    logic [5:0]  col1_reg;
    logic [7:0]  tile_q_reg;
    logic        v2_reg, p_ok2_reg, last2_reg;
    logic [5:0]  col2_reg;
    logic [17:0] pal_q_reg;
    logic        pix_valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [5:0]  column_reg;
    logic        last_reg;

    logic        advance, issue;
    logic [36:0] y_prod;
    logic [25:0] x_prod;
    logic [8:0]  rem_x;
    logic [7:0]  sy;
    logic [6:0]  acc_sum;
    logic        carry;
    logic [7:0]  pal_idx1;
    logic        tile_we, pal_we;
    logic [SCAN_W-1:0] tile_wa;

    assign advance = !pix_valid_reg || !pix_stall;
    assign issue   = (state_reg == ST_RUN) && advance;
    assign pop     = (state_reg == ST_IDLE) && !queue_empty && !v1_reg && !v2_reg;
    assign tile_we = pop && (head.op == OP_TILE_WR);
    assign pal_we  = pop && (head.op == OP_PAL_WR);
    assign tile_wa = SCAN_W'(head.tile_addr);

    assign y_prod  = 37'(ny_reg) * 37'(Y_MUL_C);
    assign x_prod  = 26'(nx_reg) * 26'(X_MUL_C);
    assign rem_x   = sw - nx_reg * OW9_C;
    assign sy      = (ny_reg >= 14'(sh)) ? sh - 8'd1 : ny_reg[7:0];
    assign acc_sum = 7'(acc_reg) + 7'(rx_reg);
    assign carry   = acc_sum >= OW_C;

    always_comb
    begin
        state_next = state_reg;
        ny_next    = ny_reg;
        nx_next    = nx_reg;
        rx_next    = rx_reg;
        qsh_next   = qsh_reg;
        addr_next  = addr_reg;
        acc_next   = acc_reg;
        ox_next    = ox_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && head.op == OP_ROW)
                begin
                    ny_next    = 14'(head.row) * 14'(sh);
                    nx_next    = sw;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // row and column steps by reciprocal multiply
                ny_next    = y_prod[Y_SHIFT +: 14];
                nx_next    = x_prod[X_SHIFT +: 9];
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                qsh_next   = 17'(nx_reg) * 17'(sh);
                rx_next    = rem_x[5:0];
                addr_next  = SCAN_W'(sy);
                acc_next   = '0;
                ox_next    = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    acc_next  = 6'(carry ? acc_sum - OW_C : acc_sum);
                    addr_next = addr_reg + SCAN_W'(qsh_reg) + (carry ? SCAN_W'(sh) : '0);
                    ox_next   = ox_reg + 1'b1;
                    if (ox_reg == OX_LAST)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ox_reg        <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ox_reg    <= ox_next;
            if (advance)
            begin
                v1_reg        <= issue;
                v2_reg        <= v1_reg;
                pix_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ny_reg   <= ny_next;
        nx_reg   <= nx_next;
        rx_reg   <= rx_next;
        qsh_reg  <= qsh_next;
        addr_reg <= addr_next;
        acc_reg  <= acc_next;
    end

    // tile read stage
    always_ff @(posedge clk)
    begin
        if (tile_we)
            tile_mem[tile_wa[TILE_AW-1:0]] <= head.tile_value;
        if (advance)
            tile_q_reg <= tile_mem[addr_reg[TILE_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_ok1_reg <= 32'(addr_reg) < 32'(TILE_DEPTH);
            col1_reg  <= ox_reg;
            last1_reg <= ox_reg == OX_LAST;
        end
    end

    // out-of-range tile address reads as palette index zero
    assign pal_idx1 = t_ok1_reg ? tile_q_reg : 8'd0;

    // palette read stage
    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[head.pal_index[PAL_AW-1:0]] <= head.rgb;
        if (advance)
            pal_q_reg <= pal_mem[pal_idx1[PAL_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_ok2_reg <= 32'(pal_idx1) < 32'(PALETTE_ENTRIES);
            col2_reg  <= col1_reg;
            last2_reg <= last1_reg;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg    <= p_ok2_reg ? widen6(pal_q_reg[17:12]) : 8'd0;
            green_reg  <= p_ok2_reg ? widen6(pal_q_reg[11:6]) : 8'd0;
            blue_reg   <= p_ok2_reg ? widen6(pal_q_reg[5:0]) : 8'd0;
            column_reg <= col2_reg;
            last_reg   <= last2_reg;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign column    = column_reg;
    assign last      = last_reg;

endmodule

// ===== hw/rtl/palette_nearest_downscaler.sv =====
// Nearest-neighbor downscaler with palette lookup.
// Request channel (src_valid/src_stall): kind 0 writes a palette entry,
// kind 1 writes one tile byte, kind 2 asks for one output row; kind 3 and
// out-of-range writes are taken and dropped. Requests pass through a
// two-entry queue, so the source keeps going while the pixel side waits.
// Pixel channel (pix_valid/pix_stall): OUT_WIDTH pixels per row request,
// column counting up from zero, last set on the final one.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 source width,
// index 1 source height; zero is treated as one. Write only when idle.
// Sequencing: palette and tile writes are applied as they are dequeued. A row
// first runs a reciprocal multiply for the row and column steps, then a
// setup step, then one pixel per cycle while pix_stall is low through the
// tile and palette memory read stages.
// A pixel stall freezes the whole read pipeline in place; nothing is lost.
// The next queued request starts once the read stages have drained.
// Reset clears control state and restores width 320 and height 200;
// the palette and tile memories are not cleared.
module palette_nearest_downscaler #(
    parameter int TILE_DEPTH      = pnd_pkg::TILE_DEPTH_DEF,
    parameter int OUT_WIDTH       = pnd_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT      = pnd_pkg::OUT_HEIGHT_DEF,
    parameter int PALETTE_ENTRIES = pnd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pnd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pnd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            src_valid,
    output logic                            src_stall,
    input  logic [1:0]                      kind,
    input  logic [7:0]                      palette_index,
    input  logic [5:0]                      red6,
    input  logic [5:0]                      green6,
    input  logic [5:0]                      blue6,
    input  logic [15:0]                     tile_address,
    input  logic [7:0]                      tile_value,
    input  logic [5:0]                      output_row,
    output logic                            pix_valid,
    input  logic                            pix_stall,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic [5:0]                      column,
    output logic                            last
);
    import pnd_pkg::*;

    logic [8:0] source_width_reg;
    logic [7:0] source_height_reg;
    logic [8:0] sw_eff;
    logic [7:0] sh_eff;

    logic     push, queue_full, queue_empty, pop;
    pnd_cmd_t push_cmd, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= SOURCE_WIDTH_RST;
            source_height_reg <= SOURCE_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[8:0];
                REG_SOURCE_HEIGHT: source_height_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    assign sw_eff = (source_width_reg == '0) ? 9'd1 : source_width_reg;
    assign sh_eff = (source_height_reg == '0) ? 8'd1 : source_height_reg;

    pnd_front #(
        .TILE_DEPTH      (TILE_DEPTH),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .kind          (kind),
        .palette_index (palette_index),
        .red6          (red6),
        .green6        (green6),
        .blue6         (blue6),
        .tile_address  (tile_address),
        .tile_value    (tile_value),
        .output_row    (output_row),
        .queue_full    (queue_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    pnd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    pnd_back #(
        .TILE_DEPTH      (TILE_DEPTH),
        .OUT_WIDTH       (OUT_WIDTH),
        .OUT_HEIGHT      (OUT_HEIGHT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .sw          (sw_eff),
        .sh          (sh_eff),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .column      (column),
        .last        (last)
    );

endmodule
